@@ sv/rgbhsv_pkg.sv @@
// Shared constants, types and width helpers for the RGB to HSV/HSL converter.
package rgbhsv_pkg;

   localparam int HUE_FRAC_BITS_DEF = 6;
   localparam int CH_W              = 8;
   localparam int HUE_W             = 15;
   localparam int SAT_W             = 16;
   localparam int LEV_W             = 16;
   localparam int SL_X_W            = 24;   // dividend width for saturation and level
   localparam int FIFO_DEPTH        = 4;
   localparam int REQ_DATA_W        = 24;
   localparam int RSP_DATA_W        = 48;

   localparam logic MODEL_HSV = 1'b0;
   localparam logic MODEL_HSL = 1'b1;

   typedef struct packed {
      logic hue_zero;
      logic sat_zero;
   } flags_type;

   // hue dividend is 2*60*2^F*t + c with t below 6c and c at most 255
   function automatic int hue_x_w(input int frac);
      return $clog2(720 * (2 ** frac) * 255 + 256);
   endfunction

   function automatic int entry_w(input int frac);
      return hue_x_w(frac) + CH_W + SL_X_W + CH_W + SL_X_W + $bits(flags_type);
   endfunction

endpackage

@@ sv/rgbhsv_front.sv @@
// Front end: takes a pixel, finds max/min/chroma and sets up the three divisions.
module rgbhsv_front #(
   parameter int HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_BITS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               model,
   input  logic                                               in_valid,
   output logic                                               in_ready,
   input  logic [rgbhsv_pkg::CH_W-1:0]                        in_red,
   input  logic [rgbhsv_pkg::CH_W-1:0]                        in_green,
   input  logic [rgbhsv_pkg::CH_W-1:0]                        in_blue,
   output logic                                               out_valid,
   input  logic                                               out_ready,
   output logic [rgbhsv_pkg::entry_w(HUE_FRAC_BITS)-1:0]      out_entry
);
   import rgbhsv_pkg::*;

   localparam int HX        = hue_x_w(HUE_FRAC_BITS);
   localparam int EW        = entry_w(HUE_FRAC_BITS);
   localparam int HUE_SCALE = 120 * (2 ** HUE_FRAC_BITS);

   logic [CH_W-1:0]   mx, mn, chroma;
   logic [10:0]       t;
   logic [CH_W:0]     sum;
   logic [CH_W-1:0]   d_hsl, sat_d;
   logic [HX-1:0]     hue_x;
   logic [SL_X_W-1:0] sat_x, lev_x;
   flags_type         flags;

   logic              valid_ff, valid_in;
   logic [EW-1:0]     entry_ff;

   always_comb begin
      mx = in_red;
      mn = in_red;
      if (in_green > mx) mx = in_green;
      if (in_blue > mx)  mx = in_blue;
      if (in_green < mn) mn = in_green;
      if (in_blue < mn)  mn = in_blue;
      chroma = mx - mn;

      // sextant: red wins ties, then green
      if (mx == in_red) begin
         if (in_green >= in_blue) begin
            t = 11'(in_green) - 11'(in_blue);
         end else begin
            t = 11'(in_green) + 11'(6) * 11'(chroma) - 11'(in_blue);
         end
      end else if (mx == in_green) begin
         t = 11'(in_blue) + 11'(2) * 11'(chroma) - 11'(in_red);
      end else begin
         t = 11'(in_red) + 11'(4) * 11'(chroma) - 11'(in_green);
      end
      hue_x = HX'(HX'(t) * HX'(HUE_SCALE) + HX'(chroma));

      sum   = (CH_W+1)'(mx) + (CH_W+1)'(mn);
      d_hsl = (sum <= (CH_W+1)'(255)) ? sum[CH_W-1:0] : CH_W'((CH_W+1)'(510) - sum);

      flags.hue_zero = (chroma == '0);
      if (model == MODEL_HSL) begin
         sat_d          = d_hsl;
         flags.sat_zero = (chroma == '0);
         lev_x          = SL_X_W'({sum, 15'd0}) + SL_X_W'(255);
      end else begin
         sat_d          = mx;
         flags.sat_zero = (mx == '0);
         lev_x          = SL_X_W'({mx, 16'd0}) + SL_X_W'(255);
      end
      sat_x = SL_X_W'({chroma, 16'd0}) + SL_X_W'(sat_d);
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         entry_ff <= {hue_x, chroma, sat_x, sat_d, lev_x, flags};
      end
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;

endmodule

@@ sv/rgbhsv_fifo.sv @@
// Short register queue between the front and back ends.
module rgbhsv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rgbhsv_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import rgbhsv_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/rgbhsv_div.sv @@
// Four-stage divide of x by 2*d (d up to 255) via reciprocal table and one correction.
module rgbhsv_div #(
   parameter int XW = rgbhsv_pkg::SL_X_W
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [XW-1:0]              x,
   input  logic [rgbhsv_pkg::CH_W-1:0] d,
   output logic [XW-1:0]              q
);
   import rgbhsv_pkg::*;

   localparam int MW = XW + CH_W + 1;

   logic [XW-1:0]   recip_tab [2**CH_W];

   // ceil(2^XW / 2d): the estimate is never low and at most one too high
   for (genvar i = 0; i < 2**CH_W; i++) begin : g_recip
      if (i == 0) begin : g_zero
         assign recip_tab[i] = '0;
      end else begin : g_val
         localparam longint RV = ((longint'(1) << XW) + longint'(2 * i - 1)) / longint'(2 * i);
         assign recip_tab[i] = XW'(RV);
      end
   end

   logic [XW-1:0]   r_ff, x1_ff, x2_ff, x3_ff, q0_ff, q0_in, q_ff, q_in;
   logic [CH_W-1:0] d1_ff, d2_ff;
   logic [2*XW-1:0] p_ff;
   logic [MW-1:0]   m_ff;

   assign q0_in = p_ff[2*XW-1:XW];
   assign q_in  = (m_ff > MW'(x3_ff)) ? q0_ff - XW'(1) : q0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff  <= recip_tab[d];
         x1_ff <= x;
         d1_ff <= d;

         p_ff  <= (2*XW)'(x1_ff) * (2*XW)'(r_ff);
         x2_ff <= x1_ff;
         d2_ff <= d1_ff;

         q0_ff <= q0_in;
         m_ff  <= MW'(q0_in) * MW'({d2_ff, 1'b0});
         x3_ff <= x2_ff;

         q_ff  <= q_in;
      end
   end

   assign q = q_ff;

endmodule

@@ sv/rgbhsv_back.sv @@
// Back end: hue, saturation and level divides with aligned flags and output stage.
module rgbhsv_back #(
   parameter int HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_pop,
   input  logic [rgbhsv_pkg::entry_w(HUE_FRAC_BITS)-1:0] in_entry,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [rgbhsv_pkg::HUE_W-1:0]                  out_hue,
   output logic [rgbhsv_pkg::SAT_W-1:0]                  out_sat,
   output logic [rgbhsv_pkg::LEV_W-1:0]                  out_level
);
   import rgbhsv_pkg::*;

   localparam int HX       = hue_x_w(HUE_FRAC_BITS);
   localparam int HUE_FULL = 360 * (2 ** HUE_FRAC_BITS);
   localparam int LAT      = 4;

   logic [HX-1:0]     hue_x, hue_q, hue_wrap;
   logic [CH_W-1:0]   hue_d, sat_d;
   logic [SL_X_W-1:0] sat_x, lev_x, sat_q, lev_q;
   flags_type         flags, flags_ff [LAT];
   logic [LAT-1:0]    v_ff;
   logic              en;

   assign {hue_x, hue_d, sat_x, sat_d, lev_x, flags} = in_entry;

   // whole pipeline stalls only when the last stage holds an untaken result
   assign en     = !v_ff[LAT-1] || out_ready;
   assign in_pop = en && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff[0] <= flags;
         for (int i = 1; i < LAT; i++) begin
            flags_ff[i] <= flags_ff[i-1];
         end
      end
   end

   rgbhsv_div #(.XW(HX)) u_hue_div (
      .clock (clock),
      .en    (en),
      .x     (hue_x),
      .d     (hue_d),
      .q     (hue_q)
   );

   rgbhsv_div #(.XW(SL_X_W)) u_sat_div (
      .clock (clock),
      .en    (en),
      .x     (sat_x),
      .d     (sat_d),
      .q     (sat_q)
   );

   rgbhsv_div #(.XW(SL_X_W)) u_lev_div (
      .clock (clock),
      .en    (en),
      .x     (lev_x),
      .d     (CH_W'(255)),
      .q     (lev_q)
   );

   // a hue that rounds up to a full turn wraps to zero
   assign hue_wrap  = (hue_q >= HX'(HUE_FULL)) ? hue_q - HX'(HUE_FULL) : hue_q;
   assign out_valid = v_ff[LAT-1];
   assign out_hue   = flags_ff[LAT-1].hue_zero ? '0 : hue_wrap[HUE_W-1:0];
   assign out_sat   = flags_ff[LAT-1].sat_zero ? '0 : sat_q[SAT_W-1:0];
   assign out_level = lev_q[LEV_W-1:0];

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v_ff[LAT-1] && !out_ready) |=> $stable(v_ff))
      else $error("back pipeline moved while output stalled");

   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      in_pop |=> v_ff[0])
      else $error("popped transaction lost at first stage");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_sat <= SAT_W'(32768)))
      else $error("saturation above 1.0");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !flags_ff[LAT-1].hue_zero) |-> (hue_wrap < HX'(HUE_FULL)))
      else $error("hue not below a full turn");

endmodule

@@ sv/rgb_to_hsv_hsl_converter.sv @@
// Top level of the RGB to HSV/HSL pixel converter.
// An accepted input passes the front register, the queue, then a 4-stage
// reciprocal-multiply divide. Throughput: one pixel per cycle unless rsp_tready
// stalls the output; set by the pipelined dividers, queue depth 4.
// Reset: synchronous, active high; clears the handshake state and selects HSV.
module rgb_to_hsv_hsl_converter #(
   parameter int HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data,   // output_model
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rgbhsv_pkg::REQ_DATA_W-1:0]   req_tdata,     // red, green, blue
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rgbhsv_pkg::RSP_DATA_W-1:0]   rsp_tdata      // hue, saturation, level, pad
);
   import rgbhsv_pkg::*;

   localparam int EW = entry_w(HUE_FRAC_BITS);

   logic          model_ff;
   logic          front_valid, fifo_full, fifo_empty, fifo_pop;
   logic [EW-1:0] front_entry, fifo_entry;
   logic [HUE_W-1:0] hue;
   logic [SAT_W-1:0] sat;
   logic [LEV_W-1:0] level;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff <= MODEL_HSV;
      end else if (csr_wr_en) begin
         model_ff <= csr_wr_data;
      end
   end

   rgbhsv_front #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .model     (model_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_red    (req_tdata[7:0]),
      .in_green  (req_tdata[15:8]),
      .in_blue   (req_tdata[23:16]),
      .out_valid (front_valid),
      .out_ready (!fifo_full),
      .out_entry (front_entry)
   );

   rgbhsv_fifo #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_entry),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_entry),
      .empty     (fifo_empty)
   );

   rgbhsv_back #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!fifo_empty),
      .in_pop    (fifo_pop),
      .in_entry  (fifo_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hue   (hue),
      .out_sat   (sat),
      .out_level (level)
   );

   assign rsp_tdata = {1'b0, level, sat, hue};

endmodule
